### src/bmpg_pkg.sv
`timescale 1ns / 1ps

package bmpg_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_BOX_WIDTH       = 3'd0,
    CFG_BOX_HEIGHT      = 3'd1,
    CFG_BOX_DEPTH       = 3'd2,
    CFG_WIDTH_SEGMENTS  = 3'd3,
    CFG_HEIGHT_SEGMENTS = 3'd4,
    CFG_DEPTH_SEGMENTS  = 3'd5
  } cfg_index_e;

  // face codes, also used as normal codes
  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  // axis numbers
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam int SegW  = 9;
  localparam int ExtW  = 16;
  localparam int IdxW  = 19;
  localparam int TexW  = 17;
  localparam int QuoW  = 25;

  // per-face axis assignment; segment counts follow the first and second axes
  typedef struct packed {
    logic [1:0] ax_u;
    logic [1:0] ax_v;
    logic [1:0] ax_w;
    logic       neg_u;
    logic       neg_v;
    logic       neg_w;
  } face_desc_t;

  function automatic face_desc_t face_desc(input logic [2:0] f);
    face_desc_t d;
    case (f)
      FACE_PX: d = '{AxisZ, AxisY, AxisX, 1'b1, 1'b1, 1'b0};
      FACE_NX: d = '{AxisZ, AxisY, AxisX, 1'b0, 1'b1, 1'b1};
      FACE_PY: d = '{AxisX, AxisZ, AxisY, 1'b0, 1'b0, 1'b0};
      FACE_NY: d = '{AxisX, AxisZ, AxisY, 1'b0, 1'b1, 1'b1};
      FACE_PZ: d = '{AxisX, AxisY, AxisZ, 1'b0, 1'b1, 1'b0};
      FACE_NZ: d = '{AxisX, AxisY, AxisZ, 1'b1, 1'b1, 1'b1};
      default: d = '{AxisZ, AxisY, AxisX, 1'b1, 1'b1, 1'b0};
    endcase
    return d;
  endfunction

  // finished request handed to the output stage
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [2:0]         normal_code;
    logic [TexW-1:0]    tex_u;
    logic [TexW-1:0]    tex_v;
    logic [IdxW-1:0]    ia;
    logic [IdxW-1:0]    ib;
    logic [IdxW-1:0]    ic;
    logic [IdxW-1:0]    id;
    logic               pair;
    logic               err;
  } res_t;

endpackage

### src/bmpg_div.sv
`timescale 1ns / 1ps

module bmpg_div #(
  parameter int NUM_W  = 25,
  parameter int DEN_W  = 9,
  parameter int STAGES = 5
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  localparam int Sps  = (NUM_W + STAGES - 1) / STAGES;
  localparam int PadW = Sps * STAGES;

  logic [PadW-1:0]  a_q [STAGES];
  logic [DEN_W:0]   r_q [STAGES];
  logic [DEN_W-1:0] d_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [PadW-1:0]  a_in;
    logic [DEN_W:0]   r_in;
    logic [DEN_W-1:0] d_in;
    logic [PadW-1:0]  a_d;
    logic [DEN_W:0]   r_d;

    if (s == 0) begin : g_first
      assign a_in = PadW'(num_i);
      assign r_in = '0;
      assign d_in = den_i;
    end else begin : g_next
      assign a_in = a_q[s-1];
      assign r_in = r_q[s-1];
      assign d_in = d_q[s-1];
    end

    // restoring division, a few quotient bits per stage
    always_comb begin
      a_d = a_in;
      r_d = r_in;
      for (int k = 0; k < Sps; k++) begin
        r_d = {r_d[DEN_W-1:0], a_d[PadW-1]};
        a_d = {a_d[PadW-2:0], 1'b0};
        if (r_d >= {1'b0, d_in}) begin
          r_d    = r_d - {1'b0, d_in};
          a_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[s] <= a_d;
        r_q[s] <= r_d;
        d_q[s] <= d_in;
      end
    end
  end

  assign quo_o = a_q[STAGES-1][NUM_W-1:0];

endmodule

### src/bmpg_out.sv
`timescale 1ns / 1ps

module bmpg_out
  import bmpg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  res_t         res_i,
  output logic         en_o,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, normal_code, tex_u, tex_v, idx0, idx1, idx2, zero fill
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // error
  output logic         m_axis_tuser
);

  logic vld_q, vld_d;
  logic beat_q, beat_d;
  res_t res_q;
  logic final_beat;

  assign final_beat = !res_q.pair || beat_q;
  assign en_o       = !vld_q || (m_axis_tready && final_beat);

  // beat control: a cell result goes out as two transactions
  always_comb begin
    vld_d  = vld_q;
    beat_d = beat_q;
    if (en_o) begin
      vld_d  = valid_i;
      beat_d = 1'b0;
    end else if (m_axis_tready) begin
      beat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beat_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tlast  = final_beat;
  assign m_axis_tuser  = res_q.err;
  assign m_axis_tdata  = {2'b00,
                          res_q.id,
                          beat_q ? res_q.ic : res_q.ib,
                          beat_q ? res_q.ib : res_q.ia,
                          res_q.tex_v, res_q.tex_u, res_q.normal_code,
                          res_q.pos_z, res_q.pos_y, res_q.pos_x};

endmodule

### src/box_mesh_point_generator.sv
`timescale 1ns / 1ps

// Box mesh point generator: answers vertex and cell requests for a box whose
// size and per-axis segment counts sit in configuration registers. A request
// is accepted every cycle unless the output port stalls the pipeline; its
// result passes the stage 1 and 2 registers, the fully pipelined five-stage
// dividers for positions and texture coordinates and the output register.
// Vertex requests and errors leave as one transaction, cell requests as two;
// the pipeline waits for the second. Configuration writes are always ready.

module box_mesh_point_generator
  import bmpg_pkg::*;
#(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // face, col, row, zero fill
  input  logic [23:0]  s_axis_tdata,
  // command
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, normal_code, tex_u, tex_v, idx0, idx1, idx2, zero fill
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // error
  output logic         m_axis_tuser
);

  localparam int DivStages = 5;

  typedef struct packed {
    logic             cmd;
    logic             ok;
    logic [2:0]       face;
    face_desc_t       fd;
    logic [SegW-1:0]  col;
    logic [SegW-1:0]  row;
    logic [SegW-1:0]  gx;
    logic [SegW-1:0]  gy;
    logic [ExtW-1:0]  ext_u;
    logic [ExtW-1:0]  ext_v;
    logic [ExtW-1:0]  ext_w;
  } s1_t;

  typedef struct packed {
    logic             cmd;
    logic             ok;
    logic [2:0]       face;
    face_desc_t       fd;
    logic [14:0]      half_u;
    logic [14:0]      half_v;
    logic [14:0]      half_w;
    logic             ew_nz;
    logic [SegW-1:0]  col;
    logic [IdxW-1:0]  rowprod;
    logic [9:0]       gx1;
    logic [IdxW-1:0]  p_x;
    logic [IdxW-1:0]  p_y;
    logic [IdxW-1:0]  p_z;
    logic [QuoW-1:0]  num_u;
    logic [QuoW-1:0]  num_v;
    logic [QuoW-1:0]  num_tu;
    logic [QuoW-1:0]  num_tv;
    logic [SegW-1:0]  gx;
    logic [SegW-1:0]  gy;
  } s2_t;

  typedef struct packed {
    logic             cmd;
    logic             ok;
    face_desc_t       fd;
    logic [14:0]      half_u;
    logic [14:0]      half_v;
    logic [14:0]      half_w;
    logic             ew_nz;
    logic [IdxW-1:0]  off;
    logic [IdxW-1:0]  base;
    logic [9:0]       gx1;
    logic [IdxW-1:0]  ia;
    logic [IdxW-1:0]  ib;
    logic [IdxW-1:0]  ic;
    logic [IdxW-1:0]  id;
  } side_t;

  logic [ExtW-1:0] ext_q [3];
  logic [SegW-1:0] seg_q [3];

  logic            en;
  logic            v1_q, v2_q;
  logic            vs_q [DivStages];
  s1_t             s1_q, s1_d;
  s2_t             s2_q, s2_d;
  side_t           sd_q [DivStages];
  side_t           sd0_d, sd1_d;
  logic [QuoW-1:0] q_u, q_v, q_tu, q_tv;
  res_t            res;

  function automatic logic [SegW-1:0] seg_clamp(input logic [SegW-1:0] s);
    logic [SegW-1:0] r;
    r = s;
    if (s == '0) r = SegW'(1);
    else if (32'(s) > MAX_SEGMENTS) r = SegW'(MAX_SEGMENTS);
    return r;
  endfunction

  function automatic logic signed [15:0] grid_coord(input logic [QuoW-1:0] q,
                                                    input logic [14:0] h,
                                                    input logic n);
    logic signed [QuoW+1:0] x;
    logic signed [15:0]     r;
    x = $signed({2'b00, q}) - $signed({12'd0, h});
    if (n) x = -x;
    if (x > 27'sd32767) r = 16'sh7fff;
    else if (x < -27'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

  // configuration registers, segment counts kept clamped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q[0] <= 16'd256;
      ext_q[1] <= 16'd256;
      ext_q[2] <= 16'd256;
      seg_q[0] <= SegW'(1);
      seg_q[1] <= SegW'(1);
      seg_q[2] <= SegW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BOX_WIDTH:       ext_q[0] <= cfg_data_i;
        CFG_BOX_HEIGHT:      ext_q[1] <= cfg_data_i;
        CFG_BOX_DEPTH:       ext_q[2] <= cfg_data_i;
        CFG_WIDTH_SEGMENTS:  seg_q[0] <= seg_clamp(cfg_data_i[SegW-1:0]);
        CFG_HEIGHT_SEGMENTS: seg_q[1] <= seg_clamp(cfg_data_i[SegW-1:0]);
        CFG_DEPTH_SEGMENTS:  seg_q[2] <= seg_clamp(cfg_data_i[SegW-1:0]);
        default: ;
      endcase
    end
  end

  assign s_axis_tready = en;

  // stage 1: decode face and range check
  always_comb begin
    s1_d.cmd   = s_axis_tuser;
    s1_d.face  = s_axis_tdata[2:0];
    s1_d.col   = s_axis_tdata[11:3];
    s1_d.row   = s_axis_tdata[20:12];
    s1_d.fd    = face_desc(s1_d.face);
    s1_d.gx    = seg_q[s1_d.fd.ax_u];
    s1_d.gy    = seg_q[s1_d.fd.ax_v];
    s1_d.ext_u = ext_q[s1_d.fd.ax_u];
    s1_d.ext_v = ext_q[s1_d.fd.ax_v];
    s1_d.ext_w = ext_q[s1_d.fd.ax_w];
    s1_d.ok    = (s1_d.face <= FACE_NZ) &&
                 (s1_d.cmd ? (s1_d.col < s1_d.gx && s1_d.row < s1_d.gy)
                           : (s1_d.col <= s1_d.gx && s1_d.row <= s1_d.gy));
  end

  // stage 2: products and divider operands
  always_comb begin
    s2_d.cmd     = s1_q.cmd;
    s2_d.ok      = s1_q.ok;
    s2_d.face    = s1_q.face;
    s2_d.fd      = s1_q.fd;
    s2_d.half_u  = s1_q.ext_u[15:1];
    s2_d.half_v  = s1_q.ext_v[15:1];
    s2_d.half_w  = s1_q.ext_w[15:1];
    s2_d.ew_nz   = (s1_q.ext_w != '0);
    s2_d.col     = s1_q.col;
    s2_d.gx1     = {1'b0, s1_q.gx} + 10'd1;
    s2_d.rowprod = IdxW'(s2_d.gx1 * s1_q.row);
    s2_d.p_x     = IdxW'(({1'b0, seg_q[2]} + 10'd1) * ({1'b0, seg_q[1]} + 10'd1));
    s2_d.p_y     = IdxW'(({1'b0, seg_q[0]} + 10'd1) * ({1'b0, seg_q[2]} + 10'd1));
    s2_d.p_z     = IdxW'(({1'b0, seg_q[0]} + 10'd1) * ({1'b0, seg_q[1]} + 10'd1));
    s2_d.num_u   = QuoW'(s1_q.col * s1_q.ext_u);
    s2_d.num_v   = QuoW'(s1_q.row * s1_q.ext_v);
    s2_d.num_tu  = QuoW'({s1_q.col, 16'd0});
    s2_d.num_tv  = QuoW'({s1_q.row, 16'd0});
    s2_d.gx      = s1_q.gx;
    s2_d.gy      = s1_q.gy;
  end

  // stage 3: face offset and in-face base index
  always_comb begin
    sd0_d        = '0;
    sd0_d.cmd    = s2_q.cmd;
    sd0_d.ok     = s2_q.ok;
    sd0_d.fd     = s2_q.fd;
    sd0_d.half_u = s2_q.half_u;
    sd0_d.half_v = s2_q.half_v;
    sd0_d.half_w = s2_q.half_w;
    sd0_d.ew_nz  = s2_q.ew_nz;
    sd0_d.gx1    = s2_q.gx1;
    sd0_d.base   = IdxW'(s2_q.col) + s2_q.rowprod;
    case (s2_q.face)
      FACE_PX: sd0_d.off = '0;
      FACE_NX: sd0_d.off = s2_q.p_x;
      FACE_PY: sd0_d.off = {s2_q.p_x[IdxW-2:0], 1'b0};
      FACE_NY: sd0_d.off = {s2_q.p_x[IdxW-2:0], 1'b0} + s2_q.p_y;
      FACE_PZ: sd0_d.off = {s2_q.p_x[IdxW-2:0], 1'b0} + {s2_q.p_y[IdxW-2:0], 1'b0};
      FACE_NZ: sd0_d.off = {s2_q.p_x[IdxW-2:0], 1'b0} + {s2_q.p_y[IdxW-2:0], 1'b0}
                           + s2_q.p_z;
      default: sd0_d.off = '0;
    endcase
  end

  // stage 4: the four corner indices of the cell
  always_comb begin
    sd1_d    = sd_q[0];
    sd1_d.ia = sd_q[0].off + sd_q[0].base;
    sd1_d.ib = sd_q[0].off + sd_q[0].base + IdxW'(sd_q[0].gx1);
    sd1_d.id = sd_q[0].off + sd_q[0].base + IdxW'(1);
    sd1_d.ic = sd_q[0].off + sd_q[0].base + IdxW'(sd_q[0].gx1) + IdxW'(1);
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int i = 0; i < DivStages; i++) vs_q[i] <= 1'b0;
    end else if (en) begin
      v1_q    <= s_axis_tvalid;
      v2_q    <= v1_q;
      vs_q[0] <= v2_q;
      for (int i = 1; i < DivStages; i++) vs_q[i] <= vs_q[i-1];
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      sd_q[0]  <= sd0_d;
      sd_q[1]  <= sd1_d;
      for (int i = 2; i < DivStages; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // dividers for grid positions and texture coordinates
  bmpg_div #(.NUM_W(QuoW), .DEN_W(SegW), .STAGES(DivStages)) u_div_u (
    .clk_i(clk_i), .en_i(en), .num_i(s2_q.num_u), .den_i(s2_q.gx), .quo_o(q_u)
  );
  bmpg_div #(.NUM_W(QuoW), .DEN_W(SegW), .STAGES(DivStages)) u_div_v (
    .clk_i(clk_i), .en_i(en), .num_i(s2_q.num_v), .den_i(s2_q.gy), .quo_o(q_v)
  );
  bmpg_div #(.NUM_W(QuoW), .DEN_W(SegW), .STAGES(DivStages)) u_div_tu (
    .clk_i(clk_i), .en_i(en), .num_i(s2_q.num_tu), .den_i(s2_q.gx), .quo_o(q_tu)
  );
  bmpg_div #(.NUM_W(QuoW), .DEN_W(SegW), .STAGES(DivStages)) u_div_tv (
    .clk_i(clk_i), .en_i(en), .num_i(s2_q.num_tv), .den_i(s2_q.gy), .quo_o(q_tv)
  );

  // final assembly: center, flip, saturate and place on the axes, or pass an error or the cell indices
  always_comb begin
    side_t              sd;
    logic signed [15:0] pos [3];
    logic signed [15:0] pw;
    sd     = sd_q[DivStages-1];
    pos[0] = '0;
    pos[1] = '0;
    pos[2] = '0;
    pw     = sd.fd.neg_w ? (16'sd0 - $signed({1'b0, sd.half_w}))
                         : $signed({1'b0, sd.half_w});
    pos[sd.fd.ax_u] = grid_coord(q_u, sd.half_u, sd.fd.neg_u);
    pos[sd.fd.ax_v] = grid_coord(q_v, sd.half_v, sd.fd.neg_v);
    pos[sd.fd.ax_w] = pw;
    res = '0;
    if (!sd.ok) begin
      res.err = 1'b1;
    end else if (!sd.cmd) begin
      res.pos_x       = pos[0];
      res.pos_y       = pos[1];
      res.pos_z       = pos[2];
      res.normal_code = {sd.fd.ax_w, 1'b0} + {2'b00, !(!sd.fd.neg_w && sd.ew_nz)};
      res.tex_u       = q_tu[TexW-1:0];
      res.tex_v       = q_tv[TexW-1:0];
    end else begin
      res.ia   = sd.ia;
      res.ib   = sd.ib;
      res.ic   = sd.ic;
      res.id   = sd.id;
      res.pair = 1'b1;
    end
  end

  bmpg_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (vs_q[DivStages-1]),
    .res_i         (res),
    .en_o          (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### bench/tb_box_mesh_point_generator.sv
`timescale 1ns / 1ps

module tb_box_mesh_point_generator;
  import bmpg_pkg::*;

  typedef struct packed {
    logic        command;
    logic [2:0]  face;
    logic [8:0]  col;
    logic [8:0]  row;
  } request_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [2:0]  normal_code;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [18:0] idx0;
    logic [18:0] idx1;
    logic [18:0] idx2;
    logic        last;
    logic        error;
  } mesh_out_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         m_axis_tuser;

  box_mesh_point_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow copy of the configuration registers
  logic [15:0] extent_q [3];
  logic [8:0]  segs_q [3];

  request_t  pending_req_q[$];
  mesh_out_t expected_out_q[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;
  int        fail_cnt;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("** box_mesh_point_generator: FAILED **");
    $finish;
  end

  // append to the tail of the request and expected-result queues
  task automatic add_request(input request_t r);
    pending_req_q.insert(pending_req_q.size(), r);
  endtask

  task automatic add_expected(input mesh_out_t o);
    expected_out_q.insert(expected_out_q.size(), o);
  endtask

  function automatic int unsigned eff_segs(input int unsigned axis);
    int unsigned s;
    s = segs_q[axis];
    if (s == 0) s = 1;
    if (s > 256) s = 256;
    return s;
  endfunction

  function automatic logic [15:0] grid_pos(input int unsigned i, input int unsigned ext,
                                           input int unsigned segs, input logic neg);
    int x;
    x = int'((i * ext) / segs) - int'(ext >> 1);
    if (neg) x = -x;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return x[15:0];
  endfunction

  // vertex index of the first vertex of a face
  function automatic int unsigned face_base(input int unsigned f);
    int unsigned sum;
    face_desc_t d;
    sum = 0;
    for (int unsigned k = 0; k < f; k++) begin
      d = face_desc(k[2:0]);
      sum += (eff_segs(d.ax_u) + 1) * (eff_segs(d.ax_v) + 1);
    end
    return sum;
  endfunction

  task automatic predict_mesh(input request_t r);
    mesh_out_t  o;
    mesh_out_t  o2;
    face_desc_t d;
    int unsigned gx, gy, ew, off, gx1;
    logic [15:0] pos [3];
    logic        ok;
    o = '0;
    o2 = '0;
    d = face_desc(r.face);
    gx = eff_segs(d.ax_u);
    gy = eff_segs(d.ax_v);
    if (r.face > FACE_NZ) ok = 1'b0;
    else if (r.command) ok = (r.col < gx) && (r.row < gy);
    else ok = (r.col <= gx) && (r.row <= gy);
    if (!ok) begin
      o.last = 1'b1;
      o.error = 1'b1;
      add_expected(o);
    end else if (!r.command) begin
      ew = extent_q[d.ax_w];
      pos[d.ax_u] = grid_pos(r.col, extent_q[d.ax_u], gx, d.neg_u);
      pos[d.ax_v] = grid_pos(r.row, extent_q[d.ax_v], gy, d.neg_v);
      pos[d.ax_w] = d.neg_w ? -(ew >> 1) : (ew >> 1);
      o.pos_x = pos[0];
      o.pos_y = pos[1];
      o.pos_z = pos[2];
      o.normal_code = 3'(2 * d.ax_w + ((!d.neg_w && ew > 0) ? 0 : 1));
      o.tex_u = 17'((r.col * 65536) / gx);
      o.tex_v = 17'((r.row * 65536) / gy);
      o.last = 1'b1;
      add_expected(o);
    end else begin
      off = face_base(r.face);
      gx1 = gx + 1;
      o.idx0 = 19'(off + r.col + gx1 * r.row);
      o.idx1 = 19'(off + r.col + gx1 * (r.row + 1));
      o.idx2 = 19'(off + r.col + 1 + gx1 * r.row);
      o2.idx0 = o.idx1;
      o2.idx1 = 19'(off + r.col + 1 + gx1 * (r.row + 1));
      o2.idx2 = o.idx2;
      o2.last = 1'b1;
      add_expected(o);
      add_expected(o2);
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          request_t r;
          r = pending_req_q.pop_front();
          predict_mesh(r);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b0, r.row, r.col, r.face};
          s_axis_tuser  <= r.command;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        mesh_out_t e;
        if (expected_out_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_cnt++;
        end else begin
          e = expected_out_q.pop_front();
          if (m_axis_tdata[15:0] !== e.pos_x) begin
            $error("pos_x exp %h got %h", e.pos_x, m_axis_tdata[15:0]); fail_cnt++;
          end
          if (m_axis_tdata[31:16] !== e.pos_y) begin
            $error("pos_y exp %h got %h", e.pos_y, m_axis_tdata[31:16]); fail_cnt++;
          end
          if (m_axis_tdata[47:32] !== e.pos_z) begin
            $error("pos_z exp %h got %h", e.pos_z, m_axis_tdata[47:32]); fail_cnt++;
          end
          if (m_axis_tdata[50:48] !== e.normal_code) begin
            $error("normal_code exp %0d got %0d", e.normal_code, m_axis_tdata[50:48]);
            fail_cnt++;
          end
          if (m_axis_tdata[67:51] !== e.tex_u) begin
            $error("tex_u exp %0d got %0d", e.tex_u, m_axis_tdata[67:51]); fail_cnt++;
          end
          if (m_axis_tdata[84:68] !== e.tex_v) begin
            $error("tex_v exp %0d got %0d", e.tex_v, m_axis_tdata[84:68]); fail_cnt++;
          end
          if (m_axis_tdata[103:85] !== e.idx0) begin
            $error("idx0 exp %0d got %0d", e.idx0, m_axis_tdata[103:85]); fail_cnt++;
          end
          if (m_axis_tdata[122:104] !== e.idx1) begin
            $error("idx1 exp %0d got %0d", e.idx1, m_axis_tdata[122:104]); fail_cnt++;
          end
          if (m_axis_tdata[141:123] !== e.idx2) begin
            $error("idx2 exp %0d got %0d", e.idx2, m_axis_tdata[141:123]); fail_cnt++;
          end
          if (m_axis_tdata[143:142] !== 2'b0) begin
            $error("fill exp 0 got %b", m_axis_tdata[143:142]); fail_cnt++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last exp %b got %b", e.last, m_axis_tlast); fail_cnt++;
          end
          if (m_axis_tuser !== e.error) begin
            $error("error exp %b got %b", e.error, m_axis_tuser); fail_cnt++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one register write; valid stays up for the next write of a batch
  task automatic write_reg(input cfg_index_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_BOX_WIDTH:       extent_q[0] = val;
      CFG_BOX_HEIGHT:      extent_q[1] = val;
      CFG_BOX_DEPTH:       extent_q[2] = val;
      CFG_WIDTH_SEGMENTS:  segs_q[0] = val[8:0];
      CFG_HEIGHT_SEGMENTS: segs_q[1] = val[8:0];
      CFG_DEPTH_SEGMENTS:  segs_q[2] = val[8:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_req_q.size() > 0 || s_axis_tvalid || expected_out_q.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_box(input logic [15:0] w, input logic [15:0] h, input logic [15:0] dp,
                         input logic [15:0] sw, input logic [15:0] sh, input logic [15:0] sd);
    write_reg(CFG_BOX_WIDTH, w);
    write_reg(CFG_BOX_HEIGHT, h);
    write_reg(CFG_BOX_DEPTH, dp);
    write_reg(CFG_WIDTH_SEGMENTS, sw);
    write_reg(CFG_HEIGHT_SEGMENTS, sh);
    write_reg(CFG_DEPTH_SEGMENTS, sd);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly in-range requests, some out of range
  task automatic queue_random(input int n);
    request_t r;
    face_desc_t d;
    int unsigned gx, gy;
    for (int i = 0; i < n; i++) begin
      r.command = 1'($urandom_range(1));
      r.face = 3'($urandom_range(5));
      d = face_desc(r.face);
      gx = eff_segs(d.ax_u);
      gy = eff_segs(d.ax_v);
      if ($urandom_range(9) == 0) begin
        r.face = 3'($urandom);
        r.col = 9'($urandom);
        r.row = 9'($urandom);
      end else begin
        r.col = 9'($urandom_range(gx - r.command));
        r.row = 9'($urandom_range(gy - r.command));
      end
      add_request(r);
    end
  endtask

  initial begin
    fail_cnt = 0;
    hold_cycles = 0;
    send_idle_pct = 34;
    recv_idle_pct = 69;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_BOX_WIDTH;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    extent_q = '{16'd256, 16'd256, 16'd256};
    segs_q = '{9'd1, 9'd1, 9'd1};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset geometry, every face, both commands, errors
    for (int f = 0; f < 8; f++) begin
      add_request('{1'b0, 3'(f), 9'd1, 9'd0});
      add_request('{1'b1, 3'(f), 9'd0, 9'd0});
    end
    add_request('{1'b0, FACE_PX, 9'd2, 9'd0});
    add_request('{1'b1, FACE_PY, 9'd1, 9'd0});
    add_request('{1'b0, FACE_NZ, 9'd511, 9'd511});
    wait_drained();

    // saturation, zero extent and clamped segment counts
    set_box(16'hFFFF, 16'd0, 16'd1, 16'd0, 16'h1FF, 16'd256);
    for (int f = 0; f < 6; f++) begin
      add_request('{1'b0, 3'(f), 9'd256, 9'd256});
      add_request('{1'b1, 3'(f), 9'd255, 9'd0});
    end
    add_request('{1'b0, FACE_PZ, 9'd1, 9'd256});
    add_request('{1'b1, FACE_NX, 9'd0, 9'd256});
    wait_drained();

    // random phases with changing settings and idling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 69; recv_idle_pct = 34; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      set_box(16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom_range(ph < 3 ? 8 : 300)), 16'($urandom_range(ph < 3 ? 8 : 300)),
              16'($urandom_range(ph < 3 ? 8 : 300)));
      if (ph == 5) begin
        set_box(16'd0, 16'hFFFF, 16'd0, 16'd256, 16'd1, 16'd256);
        hold_cycles = 300;
      end
      queue_random(200);
      wait_drained();
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (fail_cnt == 0 && expected_out_q.size() == 0)
      $display("** box_mesh_point_generator: PASSED **");
    else
      $display("** box_mesh_point_generator: FAILED **");
    $finish;
  end

endmodule
